/* src/spi_pkg.sv */
// Shared constants and types for the segment versus polyline intersection block.
package spi_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 256;
  localparam int unsigned COORD_BITS_DEF   = 16;

  localparam int unsigned OP_W = 2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // ring shift control: push inserts at cell 0, rot turns the ring toward cell 0
  typedef struct packed {
    logic push;
    logic rot;
  } spi_shift_t;

  // per scan step enables for the edge test unit
  typedef struct packed {
    logic match_en;
    logic edge_en;
  } spi_step_t;

endpackage

/* src/segment_polyline_intersect.sv */
// Top level: polyline vertex ring, scan sequencer and result register.
//
//  channel | dir | fields (low bit first)                 | note
//  in_     | in  | tuser: op ; tdata: x0, y0, x1, y1      | one item per accept
//  out_    | out | tdata: hit, truncated                  | one item per query
//
// A query rotates the vertex ring once all the way round, one cell per cycle past
// the edge test unit, so the time to its result does not depend on the vertex count.
// Synchronous active-low reset empties the polyline; vertex cells are not reset.
// in_tready is high whenever no query is in flight; a waiting result holds only
// the end of the next query.
module segment_polyline_intersect import spi_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]         in_tdata,  // x0, y0, x1, y1
  input  logic [OP_W-1:0]                           in_tuser,  // op
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [7:0]                                out_tdata  // hit, truncated
);

  localparam int unsigned IDXW = $clog2(MAX_VERTICES);
  localparam int unsigned CNTW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned C    = COORD_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_t;

  state_t           state_r, state_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDXW-1:0]  t_r, t_nxt;
  logic [1:0]       dcnt_r, dcnt_nxt;
  logic             acc_r, acc_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic             out_trunc_r, out_trunc_nxt;

  logic signed [C-1:0] ax0_r, ay0_r, ax1_r, ay1_r;
  logic signed [C:0]   ux_r, uy_r;

  logic signed [C-1:0] in_x0, in_y0, in_x1, in_y1;
  logic                in_acc;
  logic                test_hit;
  spi_shift_t          shift;
  spi_step_t           step;

  logic signed [C-1:0] cx [MAX_VERTICES];
  logic signed [C-1:0] cy [MAX_VERTICES];
  logic signed [C-1:0] lx [MAX_VERTICES];
  logic signed [C-1:0] ly [MAX_VERTICES];
  logic signed [C-1:0] hx [MAX_VERTICES];
  logic signed [C-1:0] hy [MAX_VERTICES];

  assign in_x0  = in_tdata[C-1:0];
  assign in_y0  = in_tdata[2*C-1:C];
  assign in_x1  = in_tdata[3*C-1:2*C];
  assign in_y1  = in_tdata[4*C-1:3*C];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc = in_tvalid && in_tready;

  assign shift.push = in_acc && (in_tuser == OP_APPEND) && (cnt_r < CNTW'(MAX_VERTICES));
  assign shift.rot  = (state_r == ST_SCAN);

  assign step.match_en = (state_r == ST_SCAN) && (CNTW'(t_r) < cnt_r);
  assign step.edge_en  = (state_r == ST_SCAN) && ((CNTW'(t_r) + CNTW'(1)) < cnt_r);

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_ring
    if (k == 0) begin : g_first
      assign lx[k] = in_x0;
      assign ly[k] = in_y0;
    end else begin : g_mid_lo
      assign lx[k] = cx[k-1];
      assign ly[k] = cy[k-1];
    end
    if (k == MAX_VERTICES - 1) begin : g_last
      assign hx[k] = cx[0];
      assign hy[k] = cy[0];
    end else begin : g_mid_hi
      assign hx[k] = cx[k+1];
      assign hy[k] = cy[k+1];
    end
    spi_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk  (clk),
      .ctl  (shift),
      .lo_x (lx[k]),
      .lo_y (ly[k]),
      .hi_x (hx[k]),
      .hi_y (hy[k]),
      .x    (cx[k]),
      .y    (cy[k])
    );
  end

  spi_test #(.COORD_BITS(COORD_BITS)) u_test (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .bx    (cx[0]),
    .by    (cy[0]),
    .px    (cx[1]),
    .py    (cy[1]),
    .ax0   (ax0_r),
    .ay0   (ay0_r),
    .ax1   (ax1_r),
    .ay1   (ay1_r),
    .ux    (ux_r),
    .uy    (uy_r),
    .hit   (test_hit)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    t_nxt          = t_r;
    dcnt_nxt       = dcnt_r;
    acc_nxt        = acc_r | test_hit;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_hit_nxt    = out_hit_r;
    out_trunc_nxt  = out_trunc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            OP_CLEAR: begin
              cnt_nxt = '0;
              ovf_nxt = 1'b0;
            end
            OP_APPEND: begin
              if (shift.push) begin
                cnt_nxt = cnt_r + CNTW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_QUERY: begin
              state_nxt = ST_SCAN;
              t_nxt     = '0;
              acc_nxt   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (t_r == IDXW'(MAX_VERTICES - 1)) begin
          state_nxt = ST_DRAIN;
          t_nxt     = '0;
          dcnt_nxt  = '0;
        end else begin
          t_nxt = t_r + IDXW'(1);
        end
      end
      ST_DRAIN: begin
        if (dcnt_r == 2'd2) begin
          state_nxt = ST_DONE;
        end
        dcnt_nxt = dcnt_r + 2'd1;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_hit_nxt    = acc_r;
          out_trunc_nxt  = ovf_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == OP_QUERY)) begin
      ax0_r <= in_x0;
      ay0_r <= in_y0;
      ax1_r <= in_x1;
      ay1_r <= in_y1;
      ux_r  <= {in_x1[C-1], in_x1} - {in_x0[C-1], in_x0};
      uy_r  <= {in_y1[C-1], in_y1} - {in_y0[C-1], in_y0};
    end
    out_hit_r   <= out_hit_nxt;
    out_trunc_r <= out_trunc_nxt;
    acc_r       <= acc_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      t_r          <= '0;
      dcnt_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      ovf_r        <= ovf_nxt;
      t_r          <= t_nxt;
      dcnt_r       <= dcnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b0, out_trunc_r, out_hit_r};

endmodule

/* src/spi_cell.sv */
// One vertex cell of the polyline ring.
module spi_cell import spi_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  spi_shift_t                   ctl,
  input  logic signed [COORD_BITS-1:0] lo_x,
  input  logic signed [COORD_BITS-1:0] lo_y,
  input  logic signed [COORD_BITS-1:0] hi_x,
  input  logic signed [COORD_BITS-1:0] hi_y,
  output logic signed [COORD_BITS-1:0] x,
  output logic signed [COORD_BITS-1:0] y
);

  logic signed [COORD_BITS-1:0] x_r, y_r, x_nxt, y_nxt;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (ctl.push) begin
      x_nxt = lo_x;
      y_nxt = lo_y;
    end else if (ctl.rot) begin
      x_nxt = hi_x;
      y_nxt = hi_y;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign x = x_r;
  assign y = y_r;

endmodule

/* src/spi_test.sv */
// Pipelined start-vertex match and proper-crossing test for one edge per cycle.
module spi_test import spi_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spi_step_t                    step,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] ax0,
  input  logic signed [COORD_BITS-1:0] ay0,
  input  logic signed [COORD_BITS-1:0] ax1,
  input  logic signed [COORD_BITS-1:0] ay1,
  input  logic signed [COORD_BITS:0]   ux,
  input  logic signed [COORD_BITS:0]   uy,
  output logic                         hit
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;

  function automatic logic signed [DW-1:0] sub_ext(input logic signed [COORD_BITS-1:0] a,
                                                   input logic signed [COORD_BITS-1:0] b);
    logic signed [DW-1:0] ae, be;
    ae = {a[COORD_BITS-1], a};
    be = {b[COORD_BITS-1], b};
    return ae - be;
  endfunction

  // returns {negative, positive} of p1 - p2
  function automatic logic [1:0] diff_sign(input logic signed [PW-1:0] p1,
                                           input logic signed [PW-1:0] p2);
    logic signed [SW-1:0] d;
    d = {p1[PW-1], p1} - {p2[PW-1], p2};
    return {d[SW-1], (!d[SW-1]) && (d != '0)};
  endfunction

  function automatic logic opposite(input logic [1:0] s, input logic [1:0] t);
    return (s[0] && t[1]) || (s[1] && t[0]);
  endfunction

  // stage 0: differences
  logic signed [DW-1:0] vx_r, vy_r, wx_r, wy_r, qx_r, qy_r, zx_r, zy_r;
  logic                 s0_match_r, s0_edge_r;
  // stage 1: products
  logic signed [PW-1:0] m_r [8];
  logic                 s1_match_r, s1_edge_r;
  logic                 hit_r, hit_nxt;
  logic [1:0]           c1, c2, c3, c4;

  always_ff @(posedge clk) begin
    vx_r <= sub_ext(bx, ax0);
    vy_r <= sub_ext(by, ay0);
    wx_r <= sub_ext(bx, ax1);
    wy_r <= sub_ext(by, ay1);
    qx_r <= sub_ext(px, ax0);
    qy_r <= sub_ext(py, ay0);
    zx_r <= sub_ext(bx, px);
    zy_r <= sub_ext(by, py);
    m_r[0] <= ux * vy_r;
    m_r[1] <= uy * vx_r;
    m_r[2] <= ux * qy_r;
    m_r[3] <= uy * qx_r;
    m_r[4] <= vx_r * zy_r;
    m_r[5] <= vy_r * zx_r;
    m_r[6] <= wx_r * zy_r;
    m_r[7] <= wy_r * zx_r;
    if (!rst_n) begin
      s0_match_r <= 1'b0;
      s0_edge_r  <= 1'b0;
      s1_match_r <= 1'b0;
      s1_edge_r  <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      s0_match_r <= step.match_en && (bx == ax0) && (by == ay0);
      s0_edge_r  <= step.edge_en;
      s1_match_r <= s0_match_r;
      s1_edge_r  <= s0_edge_r;
      hit_r      <= hit_nxt;
    end
  end

  always_comb begin
    c1 = diff_sign(m_r[0], m_r[1]);
    c2 = diff_sign(m_r[2], m_r[3]);
    c3 = diff_sign(m_r[4], m_r[5]);
    c4 = diff_sign(m_r[6], m_r[7]);
    hit_nxt = s1_match_r || (s1_edge_r && opposite(c1, c2) && opposite(c3, c4));
  end

  assign hit = hit_r;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the segment versus polyline intersection block.
module tb_top;
  import spi_pkg::*;

  localparam int unsigned VTX_MAX = MAX_VERTICES_DEF;
  localparam int unsigned ITEM_TARGET = 1500;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic hit;
    logic trunc;
  } verdict_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [15:0] x0, y0, x1, y1;
    logic known;
    logic hit;
    logic trunc;
  } vector_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = OP_CLEAR;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;

  always #6 clk = ~clk;

  segment_polyline_intersect dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  // polyline shadow
  logic signed [15:0] poly_x [VTX_MAX];
  logic signed [15:0] poly_y [VTX_MAX];
  int unsigned poly_len = 0;
  logic poly_dropped = 1'b0;

  verdict_t pending_verdicts [$];
  int unsigned mismatches = 0;
  int unsigned sent_items = 0;
  int unsigned burst_left = 0;

  function automatic int cross_sign(longint ax, longint ay, longint bx, longint by);
    longint p;
    p = ax * by - ay * bx;
    return (p > 0) ? 1 : ((p < 0) ? -1 : 0);
  endfunction

  function automatic logic predict_hit(logic signed [15:0] sx0, logic signed [15:0] sy0,
                                       logic signed [15:0] sx1, logic signed [15:0] sy1);
    longint ax, ay, ux, uy, bx, by, px, py;
    int c1, c2, c3, c4;
    logic hit;
    hit = 1'b0;
    ax = sx0;
    ay = sy0;
    ux = longint'(sx1) - ax;
    uy = longint'(sy1) - ay;
    for (int j = 0; j < poly_len; j++) begin
      bx = poly_x[j];
      by = poly_y[j];
      if (bx == ax && by == ay) begin
        hit = 1'b1;
        continue;
      end
      if (j > 0) begin
        px = poly_x[j-1];
        py = poly_y[j-1];
        c1 = cross_sign(ux, uy, bx - ax, by - ay);
        c2 = cross_sign(ux, uy, px - ax, py - ay);
        c3 = cross_sign(bx - ax, by - ay, bx - px, by - py);
        c4 = cross_sign(bx - longint'(sx1), by - longint'(sy1), bx - px, by - py);
        if (c1 * c2 < 0 && c3 * c4 < 0) hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // span 0 means the full coordinate range
  function automatic logic [15:0] pick_coord(int unsigned span);
    if (span == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2 * span)) - 16'(span);
  endfunction

  function automatic int unsigned pick_span();
    case ($urandom_range(0, 3))
      0: return 16;
      1: return 64;
      2: return 2048;
      default: return 0;
    endcase
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [15:0] x0, input logic [15:0] y0,
                           input logic [15:0] x1, input logic [15:0] y1, input bit known = 1'b0,
                           input bit k_hit = 1'b0, input bit k_trunc = 1'b0);
    int unsigned gap;
    verdict_t v;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {y1, x1, y0, x0};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    case (op)
      OP_CLEAR: begin
        poly_len = 0;
        poly_dropped = 1'b0;
      end
      OP_APPEND: begin
        if (poly_len < VTX_MAX) begin
          poly_x[poly_len] = x0;
          poly_y[poly_len] = y0;
          poly_len++;
        end else begin
          poly_dropped = 1'b1;
        end
      end
      OP_QUERY: begin
        if (known) begin
          v.hit = k_hit;
          v.trunc = k_trunc;
        end else begin
          v.hit = predict_hit(x0, y0, x1, y1);
          v.trunc = poly_dropped;
        end
        pending_verdicts.push_back(v);
      end
      default: ;
    endcase
    if (op != OP_UNUSED) sent_items++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // result side: stall patterns, one long hold-off, checks
  initial begin : result_sink
    verdict_t want;
    int unsigned results_seen, hold_left, mode, mode_left, cyc;
    bit hold_done;
    results_seen = 0;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    cyc = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_verdicts.size() == 0) begin
          if (mismatches < 10) $display("unexpected result item: tdata=%h", out_tdata);
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_tdata[0] !== want.hit || out_tdata[1] !== want.trunc) begin
            if (mismatches < 10)
              $display("result %0d mismatch: hit exp %b got %b, truncated exp %b got %b",
                       results_seen, want.hit, out_tdata[0], want.trunc, out_tdata[1]);
            mismatches++;
          end
        end
        results_seen++;
      end
      if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = 1500;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 400);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(0, 1);
          2: out_tready <= ($urandom_range(0, 7) == 0);
          default: out_tready <= (cyc % 5 != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    vector_row_t dir_rows [24];
    int unsigned span, n, k, pick, idx, fills;
    logic [15:0] sx, sy;
    fills = 0;
    dir_rows = '{
      '{OP_QUERY,  16'h0000, 16'h0000, 16'h0010, 16'h0010, 1'b1, 1'b0, 1'b0},
      '{OP_UNUSED, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 1'b0, 1'b0, 1'b0},
      '{OP_APPEND, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,  16'h0000, 16'h0000, 16'h0005, 16'h0005, 1'b1, 1'b1, 1'b0},
      '{OP_QUERY,  16'h0001, 16'h0001, 16'h0028, 16'h0028, 1'b1, 1'b0, 1'b0},
      '{OP_APPEND, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,  16'h0000, 16'h0100, 16'h0100, 16'h0000, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,  16'h0000, 16'h0100, 16'h0080, 16'h0080, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,  16'h0040, 16'h00c0, 16'h0040, 16'h00c0, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,  16'h0100, 16'h0100, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0},
      '{OP_APPEND, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
      '{OP_APPEND, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,  16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,  16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0, 1'b0, 1'b0},
      '{OP_APPEND, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,  16'h7fff, 16'h0000, 16'h0000, 16'h7fff, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,  16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0},
      '{OP_APPEND, 16'hffff, 16'hffff, 16'h1234, 16'hedcb, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,  16'hffff, 16'hffff, 16'h8000, 16'h7fff, 1'b1, 1'b1, 1'b0},
      '{OP_CLEAR,  16'ha5a5, 16'h5a5a, 16'hffff, 16'h8000, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,  16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 1'b1, 1'b0, 1'b0},
      '{OP_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0, 1'b0, 1'b0},
      '{OP_APPEND, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,  16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].x0, dir_rows[i].y0, dir_rows[i].x1,
                dir_rows[i].y1, dir_rows[i].known, dir_rows[i].hit, dir_rows[i].trunc);
    drain_results();

    while (sent_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (fills < 2 && sent_items > 300 && (pick < 3 || (fills == 0 && sent_items > 700))) begin
        // fill to capacity, query, overrun, query again
        fills++;
        send_item(OP_CLEAR, pick_coord(0), pick_coord(0), pick_coord(0), pick_coord(0));
        repeat (VTX_MAX)
          send_item(OP_APPEND, pick_coord(64), pick_coord(64), pick_coord(0), pick_coord(0));
        send_item(OP_QUERY, pick_coord(64), pick_coord(64), pick_coord(64), pick_coord(64));
        repeat ($urandom_range(1, 4))
          send_item(OP_APPEND, pick_coord(64), pick_coord(64), pick_coord(0), pick_coord(0));
        send_item(OP_QUERY, pick_coord(64), pick_coord(64), pick_coord(64), pick_coord(64));
        send_item(OP_QUERY, poly_x[VTX_MAX-1], poly_y[VTX_MAX-1], pick_coord(0), pick_coord(0));
      end else if (pick < 80) begin
        // fresh polyline, then queries against it
        span = pick_span();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(2, 12);
        k = $urandom_range(1, 6);
        send_item(OP_CLEAR, pick_coord(0), pick_coord(0), pick_coord(0), pick_coord(0));
        repeat (n)
          send_item(OP_APPEND, pick_coord(span), pick_coord(span), pick_coord(0), pick_coord(0));
        repeat (k) begin
          if (poly_len > 0 && $urandom_range(0, 3) == 0) begin
            idx = $urandom_range(0, poly_len - 1);
            sx = poly_x[idx];
            sy = poly_y[idx];
          end else begin
            sx = pick_coord(span);
            sy = pick_coord(span);
          end
          send_item(OP_QUERY, sx, sy, pick_coord(span), pick_coord(span));
        end
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6))
          send_item(2'($urandom_range(0, 3)), pick_coord(0), pick_coord(0), pick_coord(0),
                    pick_coord(0));
      end else begin
        // extend the current polyline without a clear
        span = pick_span();
        repeat ($urandom_range(0, 4))
          send_item(OP_APPEND, pick_coord(span), pick_coord(span), pick_coord(0), pick_coord(0));
        repeat ($urandom_range(1, 3))
          send_item(OP_QUERY, pick_coord(span), pick_coord(span), pick_coord(span),
                    pick_coord(span));
      end
      if ($urandom_range(0, 29) == 0) drain_results();
    end

    drain_results();
    repeat (VTX_MAX + 20) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0)
      $display("segment_polyline_intersect regression: pass");
    else
      $display("segment_polyline_intersect regression: fail");
    $finish;
  end

  initial begin : watchdog
    #(64'd25_000_000);
    $display("segment_polyline_intersect regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
src/spi_pkg.sv
src/spi_cell.sv
src/spi_test.sv
src/segment_polyline_intersect.sv
tb/sv/tb_top.sv
